>>> rtl/cpt_pkg.sv
`default_nettype none

package cpt_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [31:0] EMPTY_WORD   = 32'h0101_0101;
  localparam logic [23:0] EMPTY_RGB    = 24'h01_0101;
  localparam logic [23:0] NIBBLE_MASK  = 24'hf0_f0f0;
  localparam logic [7:0]  NO_MATCH_TAG = 8'hff;

  typedef enum logic {
    CMD_ADD    = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef logic [IDX_W-1:0] idx_t;

  // The reported slot index is the low byte of the slot number.
  function automatic logic [7:0] idx_byte(input idx_t idx);
    logic [IDX_W+7:0] wide;
    wide = {8'b0, idx};
    return wide[7:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/cpt_cell.sv
`default_nettype none

module cpt_cell
  import cpt_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         shift_i,
  input  wire  [31:0] word_i,
  output logic [31:0] word_o
);

  logic [31:0] word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= EMPTY_WORD;
    end else if (shift_i) begin
      word_q <= word_i;
    end
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

>>> rtl/cpt_ring.sv
`default_nettype none

module cpt_ring
  import cpt_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         shift_i,
  input  wire  [31:0] tail_i,
  output logic [31:0] head_o
);

  logic [31:0] word_w [TABLE_DEPTH];

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_slot
    logic [31:0] feed_w;

    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign feed_w = tail_i;
    end else begin : g_link
      assign feed_w = word_w[i+1];
    end

    cpt_cell u_slot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .word_i (feed_w),
      .word_o (word_w[i])
    );
  end

  assign head_o = word_w[0];

endmodule

`default_nettype wire

>>> rtl/color_palette_table.sv
// Palette store of RGB colors, each with a tag byte, plus a count of used slots.
// Input channel: in_valid_i/in_ready_o carry one command word (cmd_i, red_i,
// green_i, blue_i, tag_in_i). An add stores a new color or returns the slot of
// an exact match; a lookup returns the tag of the first used slot whose upper
// four bits of red, green and blue match, or 255.
// Output channel: out_valid_o/out_ready_i carry result_value_o and add_failed_o.
// The slots sit in a ring of TABLE_DEPTH cells that rotates one slot per cycle
// in the scan and write states only, so every command scans the table at the
// ring head. A lookup, or an add that finds a match or fails, goes from
// acceptance through one rotation in the scan state to the result register.
// An add that writes a new slot needs a second rotation, in the write state,
// to bring that slot to the head. One command is in flight at a time; the next
// word is accepted in the cycle after the result register loads, even while
// that result waits for the receiver.
// Reset sets every slot to the empty mark r = g = b = 1 with tag 1 and clears
// the count. When the receiver stalls, a finished result waits in its final
// state until the output register is free.
`default_nettype none

module color_palette_table
  import cpt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        cmd_i,
  input  wire  [7:0] red_i,
  input  wire  [7:0] green_i,
  input  wire  [7:0] blue_i,
  input  wire  [7:0] tag_in_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] result_value_o,
  output logic       add_failed_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  state_e      state_q;
  cmd_e        cmd_q;
  logic [23:0] rgb_q;
  logic [7:0]  tag_q;
  idx_t        pos_q;
  idx_t        used_q;
  logic        match_found_q;
  logic [7:0]  match_val_q;
  logic        empty_found_q;
  idx_t        empty_idx_q;
  logic [7:0]  res_q;
  logic        fail_q;
  logic        out_valid_q;
  logic [7:0]  result_value_q;
  logic        add_failed_q;

  logic [31:0] head_w;
  logic [31:0] tail_w;
  logic        shift_en;
  logic [23:0] head_rgb;
  logic        pos_last;
  idx_t        pos_d;
  logic        in_used;
  logic        exact_hit;
  logic        coarse_hit;
  logic        empty_hit;
  logic        write_hit;
  logic        match_now;
  logic [7:0]  match_val_now;
  logic        empty_now;
  idx_t        empty_idx_now;

  cpt_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .shift_i(shift_en),
    .tail_i (tail_w),
    .head_o (head_w)
  );

  always_comb begin
    head_rgb   = head_w[31:8];
    pos_last   = (pos_q == IDX_W'(TABLE_DEPTH - 1));
    pos_d      = pos_last ? '0 : pos_q + IDX_W'(1);
    in_used    = (pos_q < used_q);
    exact_hit  = in_used && (head_rgb == rgb_q);
    coarse_hit = in_used && ((head_rgb & NIBBLE_MASK) == (rgb_q & NIBBLE_MASK));
    empty_hit  = (head_rgb == EMPTY_RGB) && !pos_last;
    write_hit  = (state_q == ST_WRITE) && (pos_q == empty_idx_q);
    shift_en   = (state_q == ST_SCAN) || (state_q == ST_WRITE);
    tail_w     = write_hit ? {rgb_q, tag_q} : head_w;

    if (match_found_q) begin
      match_now     = 1'b1;
      match_val_now = match_val_q;
    end else if (cmd_q == CMD_ADD) begin
      match_now     = exact_hit;
      match_val_now = idx_byte(pos_q);
    end else begin
      match_now     = coarse_hit;
      match_val_now = head_w[7:0];
    end

    empty_now     = empty_found_q || empty_hit;
    empty_idx_now = empty_found_q ? empty_idx_q : pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= CMD_ADD;
      rgb_q          <= '0;
      tag_q          <= '0;
      pos_q          <= '0;
      used_q         <= '0;
      match_found_q  <= 1'b0;
      match_val_q    <= '0;
      empty_found_q  <= 1'b0;
      empty_idx_q    <= '0;
      res_q          <= '0;
      fail_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      result_value_q <= '0;
      add_failed_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            cmd_q         <= cmd_e'(cmd_i);
            rgb_q         <= {red_i, green_i, blue_i};
            tag_q         <= tag_in_i;
            match_found_q <= 1'b0;
            empty_found_q <= 1'b0;
            state_q       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pos_q         <= pos_d;
          match_found_q <= match_now;
          match_val_q   <= match_val_now;
          empty_found_q <= empty_now;
          empty_idx_q   <= empty_idx_now;
          if (pos_last) begin
            fail_q <= 1'b0;
            if (cmd_q == CMD_LOOKUP) begin
              res_q   <= match_now ? match_val_now : NO_MATCH_TAG;
              state_q <= ST_DONE;
            end else if (match_now) begin
              res_q   <= match_val_now;
              state_q <= ST_DONE;
            end else if (empty_now) begin
              res_q   <= idx_byte(empty_idx_now);
              state_q <= ST_WRITE;
            end else begin
              res_q   <= NO_MATCH_TAG;
              fail_q  <= 1'b1;
              state_q <= ST_DONE;
            end
          end
        end
        ST_WRITE: begin
          pos_q <= pos_d;
          if (write_hit) begin
            used_q <= empty_idx_q + IDX_W'(1);
          end
          if (pos_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q    <= 1'b1;
            result_value_q <= res_q;
            add_failed_q   <= fail_q;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_value_q;
  assign add_failed_o   = add_failed_q;

  a_idle_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> pos_q == '0)
    else $error("Ring is not in its home position while idle.");

  a_fail_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && add_failed_o |-> result_value_o == NO_MATCH_TAG)
    else $error("A failed add does not report 255.");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= IDX_W'(TABLE_DEPTH - 1))
    else $error("Used count exceeds the last writable slot.");

  a_write_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> empty_found_q && !match_found_q && cmd_q == CMD_ADD)
    else $error("Write pass started without a free slot.");

  a_write_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE && pos_last |=> used_q == $past(empty_idx_q) + IDX_W'(1))
    else $error("Used count not updated by the write pass.");

endmodule

`default_nettype wire

>>> bench/palette_checker.sv
module palette_checker
  import cpt_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_ready_i,
  input  wire        cmd_i,
  input  wire  [7:0] red_i,
  input  wire  [7:0] green_i,
  input  wire  [7:0] blue_i,
  input  wire  [7:0] tag_in_i,
  input  wire        out_valid_i,
  input  wire        out_ready_i,
  input  wire  [7:0] result_value_i,
  input  wire        add_failed_i,
  output int         fail_count_o,
  output int         pending_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] value;
    logic       failed;
  } palette_answer_t;

  logic [23:0]     slot_rgb [TABLE_DEPTH];
  logic [7:0]      slot_tag [TABLE_DEPTH];
  int unsigned     slots_used;
  palette_answer_t answers_q [$];
  palette_answer_t want;

  initial begin
    fail_count_o = 0;
    pending_count_o = 0;
  end

  function automatic palette_answer_t palette_answer(input cmd_e cmd, input logic [23:0] rgb,
                                                     input logic [7:0] tag);
    palette_answer_t ans;
    int unsigned     limit;
    bit              done;
    ans.value  = NO_MATCH_TAG;
    ans.failed = (cmd == CMD_ADD);
    limit = (slots_used > TABLE_DEPTH) ? TABLE_DEPTH : slots_used;
    done = 1'b0;
    if (cmd == CMD_ADD) begin
      for (int s = 0; s < limit && !done; s++) begin
        if (slot_rgb[s] == rgb) begin
          ans.value = 8'(s);
          ans.failed = 1'b0;
          done = 1'b1;
        end
      end
      // A new color goes to the lowest slot, other than the last, that still holds the empty mark.
      for (int s = 0; s + 1 < TABLE_DEPTH && !done; s++) begin
        if (slot_rgb[s] == EMPTY_RGB) begin
          slot_rgb[s] = rgb;
          slot_tag[s] = tag;
          slots_used = s + 1;
          ans.value = 8'(s);
          ans.failed = 1'b0;
          done = 1'b1;
        end
      end
    end else begin
      for (int s = 0; s < limit && !done; s++) begin
        if ((slot_rgb[s] & NIBBLE_MASK) == (rgb & NIBBLE_MASK)) begin
          ans.value = slot_tag[s];
          done = 1'b1;
        end
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < TABLE_DEPTH; s++) begin
        slot_rgb[s] = EMPTY_RGB;
        slot_tag[s] = EMPTY_WORD[7:0];
      end
      slots_used = 0;
      answers_q.delete();
      pending_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result word with nothing pending: value %02h failed %b",
                     $realtime, result_value_i, add_failed_i);
          end
          fail_count_o++;
        end else begin
          want = answers_q.pop_front();
          if (want.value !== result_value_i || want.failed !== add_failed_i) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch: expected value %02h failed %b, got value %02h failed %b",
                       $realtime, want.value, want.failed, result_value_i, add_failed_i);
            end
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        answers_q.push_back(palette_answer(cmd_e'(cmd_i), {red_i, green_i, blue_i}, tag_in_i));
      end
      pending_count_o = answers_q.size();
    end
  end

endmodule

>>> bench/testbench.sv
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  import cpt_pkg::*;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       cmd_i;
  logic [7:0] red_i;
  logic [7:0] green_i;
  logic [7:0] blue_i;
  logic [7:0] tag_in_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] result_value_o;
  logic       add_failed_o;
  int         fail_count;
  int         pending_count;

  logic [23:0] known_colors [$];

  always #5 clk_i = ~clk_i;

  color_palette_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .tag_in_i       (tag_in_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .add_failed_o   (add_failed_o)
  );

  palette_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .cmd_i           (cmd_i),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .tag_in_i        (tag_in_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_value_i  (result_value_o),
    .add_failed_i    (add_failed_o),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [23:0] some_known_color();
    if (known_colors.size() == 0) return 24'($urandom);
    return known_colors[$urandom_range(0, known_colors.size() - 1)];
  endfunction

  task automatic send_word(input cmd_e cmd, input logic [23:0] rgb, input logic [7:0] tag,
                           input int unsigned gap);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    {red_i, green_i, blue_i} <= rgb;
    tag_in_i <= tag;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CMD_ADD) known_colors.push_back(rgb);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The receiver holds off once for a long stretch so that the input side backs up.
  initial begin : receiver
    int          results_seen;
    int unsigned idle_left;
    bit          held;
    results_seen = 0;
    idle_left = 0;
    held = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) results_seen++;
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        idle_left = 3000;
      end else if (idle_left > 0) begin
        idle_left--;
      end else if ($urandom_range(0, 3) == 0 && !(results_seen >= 600 && results_seen < 700)) begin
        idle_left = gap_len();
      end
      out_ready_i <= (idle_left == 0);
    end
  end

  initial begin : stimulus
    int unsigned sel;
    int unsigned gap;
    logic [23:0] rgb;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_ADD;
    red_i <= 8'h00;
    green_i <= 8'h00;
    blue_i <= 8'h00;
    tag_in_i <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(CMD_LOOKUP, 24'h000000, 8'h00, gap_len());
    send_word(CMD_ADD,    24'h000000, 8'h00, gap_len());
    send_word(CMD_ADD,    24'hffffff, 8'hff, gap_len());
    send_word(CMD_ADD,    24'h000000, 8'h77, gap_len());
    send_word(CMD_LOOKUP, 24'h0f0f0f, 8'h00, gap_len());
    send_word(CMD_LOOKUP, 24'hf0f0f0, 8'hff, gap_len());
    send_word(CMD_LOOKUP, 24'h808080, 8'h00, gap_len());
    send_word(CMD_ADD,    EMPTY_RGB,  8'h5a, gap_len());
    send_word(CMD_ADD,    EMPTY_RGB,  8'ha5, gap_len());
    send_word(CMD_LOOKUP, EMPTY_RGB,  8'h00, gap_len());
    send_word(CMD_ADD,    24'h123456, 8'h3c, gap_len());
    send_word(CMD_LOOKUP, 24'h1f3f5f, 8'h00, gap_len());
    send_word(CMD_ADD,    24'hff0000, 8'h80, gap_len());
    send_word(CMD_ADD,    24'h00ff00, 8'h01, gap_len());
    send_word(CMD_ADD,    24'h0000ff, 8'hfe, gap_len());
    send_word(CMD_LOOKUP, 24'hf00000, 8'h00, gap_len());
    send_word(CMD_ADD,    24'hffffff, 8'h00, gap_len());
    send_word(CMD_LOOKUP, 24'hffffff, 8'h00, gap_len());

    // Fresh colors fill the table partway through, so later adds also hit the full case.
    for (int n = 0; n < 1150; n++) begin
      gap = (n >= 500 && n < 600) ? 0 : gap_len();
      sel = $urandom_range(0, 99);
      if (sel < 32) begin
        send_word(CMD_ADD, 24'($urandom), 8'($urandom), gap);
      end else if (sel < 50) begin
        send_word(CMD_ADD, some_known_color(), 8'($urandom), gap);
      end else if (sel < 55) begin
        send_word(CMD_ADD, EMPTY_RGB, 8'($urandom), gap);
      end else if (sel < 60) begin
        rgb = some_known_color();
        rgb[$urandom_range(0, 23)] ^= 1'b1;
        send_word(CMD_ADD, rgb, 8'($urandom), gap);
      end else if (sel < 85) begin
        rgb = (some_known_color() & NIBBLE_MASK) | (24'($urandom) & ~NIBBLE_MASK);
        send_word(CMD_LOOKUP, rgb, 8'($urandom), gap);
      end else begin
        send_word(CMD_LOOKUP, 24'($urandom), 8'($urandom), gap);
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    wait (pending_count == 0);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
